// ----- rtl/tssm_pkg.sv -----
// Package for the triple stack shared memory block.
// Holds operation, stack select and status codes and the default sizes.
// No dependencies.
package tssm_pkg;

	localparam int DefDepth     = 16;
	localparam int DefDataWidth = 32;

	localparam logic [1:0] SEL_LOW    = 2'd0;
	localparam logic [1:0] SEL_MID    = 2'd1;
	localparam logic [1:0] SEL_HIGH   = 2'd2;
	localparam logic [1:0] STACK_NONE = 2'd3;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_PEEK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

endpackage

// ----- rtl/triple_stack_shared_memory.sv -----
// Triple stack shared memory: three LIFO stacks in one element store.
// Depends on tssm_pkg.
//
// Request channel (req_valid / req_stall) carries mode, stack_sel and value.
// Response channel (rsp_valid / rsp_stall) carries data and status.
// Stack 0 grows up from address 0 and holds DEPTH/3 elements. Stack 1 grows
// up from DEPTH/3, stack 2 grows down from DEPTH-1; they share the rest.
// Every request gives exactly one response, in the cycle after it is taken.
// Throughput is one item per cycle while rsp_stall is low: the counters and one port of the store
// are used once per item, and the read data lands in the response register.
// While a response waits under rsp_stall, req_stall is high; as soon as the
// response is taken the next request is taken in the same cycle.
// Data is zero for push and for any failed operation.
// Reset clears the three counters and the response valid; store contents
// stay undefined, and read data is only used after a push has written them.
module triple_stack_shared_memory #(
	parameter int DEPTH      = tssm_pkg::DefDepth,
	parameter int DATA_WIDTH = tssm_pkg::DefDataWidth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         mode,
	input  logic [1:0]         stack_sel,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] data,
	output logic [1:0]         status
);
	import tssm_pkg::*;

	localparam int MidBase = DEPTH / 3;
	localparam int Shared  = DEPTH - MidBase;
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [CW-1:0] count_low_q, count_mid_q, count_high_q;
	logic [CW-1:0] cnt_cur, pos, addr_w;
	logic [CW:0]   shared_sum;
	logic [AW-1:0] addr;
	logic          full, do_push, do_pop, do_read, accept;
	status_t       op_status;
	logic [63:0]   wr_wide, rd_wide;
	logic [DATA_WIDTH-1:0] rd_s1;
	logic          rsp_valid_q, hit_s1;
	status_t       status_s1;

	assign accept     = req_valid & ~req_stall;
	assign req_stall  = rsp_valid_q & rsp_stall;
	assign shared_sum = {1'b0, count_mid_q} + {1'b0, count_high_q};

	always_comb begin
		case (stack_sel)
			SEL_LOW: cnt_cur = count_low_q;
			SEL_MID: cnt_cur = count_mid_q;
			default: cnt_cur = count_high_q;
		endcase
		if (stack_sel == SEL_LOW) begin
			full = count_low_q >= CW'(MidBase);
		end else begin
			full = shared_sum >= (CW+1)'(Shared);
		end
	end

	always_comb begin
		op_status = ST_OK;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_read   = 1'b0;
		if (stack_sel == STACK_NONE) begin
			op_status = ST_BAD;
		end else begin
			case (mode)
				MODE_PUSH: begin
					if (full) op_status = ST_FULL;
					else do_push = 1'b1;
				end
				MODE_POP, MODE_PEEK: begin
					if (cnt_cur == '0) begin
						op_status = ST_EMPTY;
					end else begin
						do_read = 1'b1;
						do_pop  = (mode == MODE_POP);
					end
				end
				default: op_status = ST_BAD;
			endcase
		end
	end

	always_comb begin
		pos = do_push ? cnt_cur : cnt_cur - CW'(1);
		case (stack_sel)
			SEL_LOW: addr_w = pos;
			SEL_MID: addr_w = CW'(MidBase) + pos;
			default: addr_w = CW'(DEPTH - 1) - pos;
		endcase
		addr = addr_w[AW-1:0];
	end

	assign wr_wide = {32'd0, value};

	always_ff @(posedge clk) begin
		if (accept && do_push) mem[addr] <= wr_wide[DATA_WIDTH-1:0];
		if (accept) begin
			rd_s1     <= mem[addr];
			hit_s1    <= do_read;
			status_s1 <= op_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q  <= '0;
			count_mid_q  <= '0;
			count_high_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept && (do_push || do_pop)) begin
				case (stack_sel)
					SEL_LOW: begin
						count_low_q <= do_push ? count_low_q + CW'(1)
							: count_low_q - CW'(1);
					end
					SEL_MID: begin
						count_mid_q <= do_push ? count_mid_q + CW'(1)
							: count_mid_q - CW'(1);
					end
					default: begin
						count_high_q <= do_push ? count_high_q + CW'(1)
							: count_high_q - CW'(1);
					end
				endcase
			end
		end
	end

	assign rd_wide   = 64'(rd_s1);
	assign rsp_valid = rsp_valid_q;
	assign data      = hit_s1 ? rd_wide[31:0] : 32'sd0;
	assign status    = status_s1;

	a_low_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_low_q <= CW'(MidBase))
		else $error("stack 0 count beyond its region");

	a_shared_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shared_sum <= (CW+1)'(Shared))
		else $error("stacks 1 and 2 overlap");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item gave no response");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> data == 32'sd0)
		else $error("failed operation returned data");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for triple_stack_shared_memory: directed, fill/drain, random and
// backpressure tests against a cycle-free model of the three stacks.
// Depends on tssm_pkg and the block's RTL.
module tb;
	import tssm_pkg::*;

	localparam int DEPTH       = DefDepth;
	localparam int LOW_CAP     = DEPTH / 3;
	localparam int SHARED_CAP  = DEPTH - LOW_CAP;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [31:0] data;
		status_t            status;
	} stack_rsp_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         mode      = '0;
	logic [1:0]         stack_sel = '0;
	logic signed [31:0] value     = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic signed [31:0] data;
	logic [1:0]         status;

	logic signed [31:0] stack_mem [DEPTH];
	int unsigned        stack_depth [3] = '{0, 0, 0};
	stack_rsp_t         pending_rsp [$];
	stack_rsp_t         rsp_head;
	int                 mismatches = 0;
	bit                 send_gaps  = 1'b0;
	int                 burst_left = 0;
	bit                 hold_req   = 1'b0;

	triple_stack_shared_memory #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DefDataWidth)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode     (mode),
		.stack_sel(stack_sel),
		.value    (value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.data     (data),
		.status   (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned slot_addr(logic [1:0] sel, int unsigned pos);
		case (sel)
			SEL_LOW: return pos;
			SEL_MID: return LOW_CAP + pos;
			default: return DEPTH - 1 - pos;
		endcase
	endfunction

	function automatic bit stack_full(logic [1:0] sel);
		if (sel == SEL_LOW)
			return stack_depth[SEL_LOW] >= LOW_CAP;
		return stack_depth[SEL_MID] + stack_depth[SEL_HIGH] >= SHARED_CAP;
	endfunction

	function automatic stack_rsp_t apply_stack_op(logic [1:0] m, logic [1:0] s,
			logic signed [31:0] v);
		stack_rsp_t r;
		r.data   = '0;
		r.status = ST_OK;
		if (s == STACK_NONE || m == MODE_UNUSED) begin
			r.status = ST_BAD;
		end else if (m == MODE_PUSH) begin
			if (stack_full(s)) begin
				r.status = ST_FULL;
			end else begin
				stack_mem[slot_addr(s, stack_depth[s])] = v;
				stack_depth[s]++;
			end
		end else if (stack_depth[s] == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.data = stack_mem[slot_addr(s, stack_depth[s] - 1)];
			if (m == MODE_POP)
				stack_depth[s]--;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(0, 9))
			0: return 32'sh80000000;
			1: return 32'sh7fffffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [1:0] s,
			input logic signed [31:0] v);
		int gap;
		if (send_gaps && burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		req_valid <= 1'b1;
		mode      <= m;
		stack_sel <= s;
		value     <= v;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(apply_stack_op(m, s, v));
	endtask

	task automatic send_random_op(input int push_pct);
		int          r;
		logic [1:0]  m;
		logic [1:0]  s;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			m = MODE_PUSH;
		else if (r < push_pct + (100 - push_pct) * 6 / 10)
			m = MODE_POP;
		else if (r < 96)
			m = MODE_PEEK;
		else
			m = MODE_UNUSED;
		s = ($urandom_range(0, 19) == 0) ? STACK_NONE : 2'($urandom_range(0, 2));
		send_item(m, s, random_value());
	endtask

	task automatic test_directed();
		int i;
		send_gaps = 1'b0;
		send_item(MODE_POP, SEL_LOW, $urandom);
		send_item(MODE_POP, SEL_MID, $urandom);
		send_item(MODE_POP, SEL_HIGH, $urandom);
		send_item(MODE_PEEK, SEL_HIGH, $urandom);
		send_item(MODE_PUSH, STACK_NONE, 32'sh5a5a5a5a);
		send_item(MODE_POP, STACK_NONE, $urandom);
		send_item(MODE_PEEK, STACK_NONE, $urandom);
		send_item(MODE_UNUSED, SEL_LOW, 32'sd1);
		send_item(MODE_PUSH, SEL_LOW, 32'sh80000000);
		send_item(MODE_PUSH, SEL_LOW, 32'sh7fffffff);
		send_item(MODE_PEEK, SEL_LOW, $urandom);
		send_item(MODE_POP, SEL_LOW, $urandom);
		send_item(MODE_POP, SEL_LOW, $urandom);
		send_item(MODE_PUSH, SEL_MID, -32'sd1);
		send_item(MODE_PUSH, SEL_HIGH, '0);
		send_item(MODE_PEEK, SEL_MID, $urandom);
		send_item(MODE_PEEK, SEL_HIGH, $urandom);
		send_item(MODE_POP, SEL_HIGH, $urandom);
		send_item(MODE_POP, SEL_MID, $urandom);
		for (i = 0; i <= LOW_CAP; i++)
			send_item(MODE_PUSH, SEL_LOW, random_value());
	endtask

	task automatic test_fill_drain(input int rounds);
		int         i;
		logic [1:0] s;
		send_gaps = 1'b1;
		for (i = 0; i < rounds; i++) begin
			if (i % 2 == 0) begin
				while (!stack_full(SEL_LOW))
					send_item(MODE_PUSH, SEL_LOW, random_value());
				send_item(MODE_PUSH, SEL_LOW, random_value());
				while (stack_depth[SEL_LOW] > 0) begin
					if ($urandom_range(0, 3) == 0)
						send_item(MODE_PEEK, SEL_LOW, $urandom);
					send_item(MODE_POP, SEL_LOW, $urandom);
				end
				send_item(MODE_POP, SEL_LOW, $urandom);
			end else begin
				while (!stack_full(SEL_MID))
					send_item(MODE_PUSH, 2'($urandom_range(1, 2)), random_value());
				send_item(MODE_PUSH, SEL_MID, random_value());
				send_item(MODE_PUSH, SEL_HIGH, random_value());
				while (stack_depth[SEL_MID] + stack_depth[SEL_HIGH] > 0) begin
					s = 2'($urandom_range(1, 2));
					if (stack_depth[s] == 0)
						s = (s == SEL_MID) ? SEL_HIGH : SEL_MID;
					if ($urandom_range(0, 3) == 0)
						send_item(MODE_PEEK, s, $urandom);
					send_item(MODE_POP, s, $urandom);
				end
				send_item(MODE_POP, SEL_MID, $urandom);
				send_item(MODE_POP, SEL_HIGH, $urandom);
			end
		end
	endtask

	task automatic test_random_ops(input int count);
		int i;
		int push_pct;
		send_gaps = 1'b1;
		push_pct  = 45;
		for (i = 0; i < count; i++) begin
			if (i % 50 == 0)
				push_pct = $urandom_range(20, 70);
			send_random_op(push_pct);
		end
	endtask

	task automatic test_backpressure(input int count);
		int i;
		send_gaps = 1'b0;
		hold_req  = 1'b1;
		for (i = 0; i < count; i++)
			send_random_op(45);
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected item: data %0d status %0d", data, status);
			end else begin
				rsp_head = pending_rsp.pop_front();
				if (data !== rsp_head.data || status !== rsp_head.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected data %0d status %0d, got data %0d status %0d",
							rsp_head.data, rsp_head.status, data, status);
				end
			end
		end
	end

	initial begin : rsp_sink
		logic [15:0] pattern;
		int          tick;
		pattern = '0;
		tick    = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (tick % 32 == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = '0;
					1: pattern = 16'($urandom);
					2: pattern = 16'($urandom & $urandom);
					default: pattern = 16'($urandom | $urandom);
				endcase
			end
			rsp_stall <= pattern[tick % 16];
			tick++;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain(10);
		test_random_ops(500);
		test_backpressure(80);
		test_random_ops(420);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
